// ----- design/ans_pkg.sv -----
// Shared types and constants of the Annex B NAL unit splitter.
package ans_pkg;

  localparam int BYTE_W = 8;
  localparam int OFF_W  = 24;
  localparam int LEN_W  = 25;
  localparam int TYPE_W = 5;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h01;
  localparam int                LOOK_MSB   = 7;
  localparam logic [TYPE_W-1:0] TYPE_SPS   = 5'd7;
  localparam logic [TYPE_W-1:0] TYPE_PPS   = 5'd8;
  localparam logic [1:0]        ZRUN_MAX   = 2'd3;
  localparam logic [1:0]        ZRUN_SHORT = 2'd2;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

  // pending start code progress
  typedef enum logic [2:0] {
    LA_IDLE = 3'b001,
    LA_HDR  = 3'b010,
    LA_LOOK = 3'b100
  } la_e;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
    logic [TYPE_W-1:0] nal_type;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic               room;
    logic [Q_LVL_W-1:0] level;
  } q_stat_t;

endpackage

// ----- design/ans_if.sv -----
// Byte input and unit result channel interfaces.
interface ans_byte_if;
  import ans_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_stream;
  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface ans_unit_if;
  import ans_pkg::*;
  logic              valid;
  logic              ready;
  logic [OFF_W-1:0]  unit_offset;
  logic [LEN_W-1:0]  unit_length;
  logic [TYPE_W-1:0] unit_type;
  logic              run_last;
  modport source (output valid, output unit_offset, output unit_length, output unit_type,
                  output run_last, input ready);
  modport sink   (input valid, input unit_offset, input unit_length, input unit_type,
                  input run_last, output ready);
endinterface

// ----- design/ans_core.sv -----
// Start code detection, unit tracking and result formation for one byte per cycle while the queue has room.
module ans_core #(
  parameter int POSITION_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ans_byte_if.sink         in_i,
  input  ans_pkg::q_stat_t stat_i,
  output ans_pkg::push_t   push_o
);
  import ans_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam int CW = PB + 1;

  logic [CW-1:0]     pos_q, pos_d;
  logic [1:0]        zrun_q, zrun_d;
  logic              inu_q, inu_d;
  logic              aw_q, aw_d;
  la_e               la_q, la_d;
  logic [PB-1:0]     ub_q, ub_d;
  logic [PB-1:0]     ce_q, ce_d;
  logic [PB-1:0]     pb_q, pb_d;
  logic [TYPE_W-1:0] ct_q, ct_d;
  logic [TYPE_W-1:0] pt_q, pt_d;

  logic              accept;
  logic [BYTE_W-1:0] b;
  logic [PB-1:0]     p;
  logic [PB-1:0]     code;
  logic              la_emit, eos1, eos2;
  res_t              r_la, r_e1, r_e2, s0, s1;
  logic [1:0]        n;

  function automatic logic [CW-1:0] span(input logic [CW-1:0] e, input logic [CW-1:0] s);
    return (e > s) ? e - s : '0;
  endfunction

  function automatic res_t mk(input logic [PB-1:0] bgn, input logic [CW-1:0] e,
                              input logic [TYPE_W-1:0] t);
    res_t r;
    r.offset   = OFF_W'(bgn);
    r.length   = LEN_W'(span(e, {1'b0, bgn}));
    r.nal_type = t;
    r.last     = 1'b0;
    return r;
  endfunction

  assign in_i.ready = stat_i.room;
  assign accept     = in_i.valid && stat_i.room;
  assign b          = in_i.data_byte;
  assign p          = pos_q[PB] ? {PB{1'b1}} : pos_q[PB-1:0];
  assign code       = (zrun_q == ZRUN_MAX) ? PB'(ZRUN_MAX) : PB'(ZRUN_SHORT);

  always_comb begin
    pos_d   = pos_q;
    zrun_d  = zrun_q;
    inu_d   = inu_q;
    aw_d    = aw_q;
    la_d    = la_q;
    ub_d    = ub_q;
    ce_d    = ce_q;
    pb_d    = pb_q;
    ct_d    = ct_q;
    pt_d    = pt_q;
    la_emit = 1'b0;

    // header byte or look-ahead byte of a pending start code
    if (aw_q) begin
      ub_d  = pb_q;
      ct_d  = b[TYPE_W-1:0];
      inu_d = 1'b1;
      aw_d  = 1'b0;
    end else if (la_q == LA_HDR) begin
      pt_d = b[TYPE_W-1:0];
      la_d = LA_LOOK;
    end else if (la_q == LA_LOOK) begin
      // slices merge unless the next byte has its top bit set or this is SPS/PPS
      if (b[LOOK_MSB] || ct_q == TYPE_SPS || ct_q == TYPE_PPS) begin
        la_emit = 1'b1;
        ub_d    = pb_q;
        ct_d    = pt_q;
      end
      la_d = LA_IDLE;
    end

    if (b == '0) begin
      if (zrun_q != ZRUN_MAX) zrun_d = zrun_q + 2'd1;
    end else begin
      if (b == START_BYTE && zrun_q >= ZRUN_SHORT) begin
        pb_d = (&p) ? p : p + PB'(1);
        if (inu_d) begin
          ce_d = (p >= code) ? p - code : '0;
          la_d = LA_HDR;
        end else begin
          aw_d = 1'b1;
        end
      end
      zrun_d = '0;
    end

    if (!pos_q[PB]) pos_d = pos_q + CW'(1);
  end

  assign r_la = mk(ub_q, {1'b0, ce_q}, ct_q);
  assign r_e1 = !inu_d ? mk(pb_d, {1'b0, pb_d}, '0) :
                (la_d == LA_IDLE) ? mk(ub_d, pos_d, ct_d) : mk(ub_d, {1'b0, ce_d}, ct_d);
  assign r_e2 = mk(pb_d, pos_d, (la_d == LA_LOOK) ? pt_d : '0);
  assign eos1 = in_i.end_of_stream && (inu_d || aw_d);
  assign eos2 = in_i.end_of_stream && inu_d && (la_d != LA_IDLE);
  assign n    = 2'(la_emit) + 2'(eos1) + 2'(eos2);

  always_comb begin
    s0 = la_emit ? r_la : r_e1;
    s1 = la_emit ? r_e1 : r_e2;
    s0.last = (n == 2'd1);
    s1.last = (n == 2'd2);
    push_o.cnt = accept ? n : 2'd0;
    push_o.r0  = s0;
    push_o.r1  = s1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      zrun_q <= '0;
      inu_q  <= 1'b0;
      aw_q   <= 1'b0;
      la_q   <= LA_IDLE;
      ub_q   <= '0;
      ce_q   <= '0;
      pb_q   <= '0;
      ct_q   <= '0;
      pt_q   <= '0;
    end else if (accept) begin
      if (in_i.end_of_stream) begin
        // end of stream: back to a fresh stream
        pos_q  <= '0;
        zrun_q <= '0;
        inu_q  <= 1'b0;
        aw_q   <= 1'b0;
        la_q   <= LA_IDLE;
        ub_q   <= '0;
        ce_q   <= '0;
        pb_q   <= '0;
        ct_q   <= '0;
        pt_q   <= '0;
      end else begin
        pos_q  <= pos_d;
        zrun_q <= zrun_d;
        inu_q  <= inu_d;
        aw_q   <= aw_d;
        la_q   <= la_d;
        ub_q   <= ub_d;
        ce_q   <= ce_d;
        pb_q   <= pb_d;
        ct_q   <= ct_d;
        pt_q   <= pt_d;
      end
    end
  end

endmodule

// ----- design/ans_outq.sv -----
// Result queue: takes up to two results a cycle, hands out one while out_o.ready is high.
module ans_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ans_pkg::push_t    push_i,
  ans_unit_if.source        out_o,
  output ans_pkg::q_stat_t  stat_o
);
  import ans_pkg::*;

  res_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_LVL_W-1:0] level_q;
  logic               pop;
  res_t               head;

  assign pop  = out_o.valid && out_o.ready;
  assign head = mem_q[rd_q];

  assign out_o.valid       = (level_q != '0);
  assign out_o.unit_offset = head.offset;
  assign out_o.unit_length = head.length;
  assign out_o.unit_type   = head.nal_type;
  assign out_o.run_last    = head.last;

  // room for a worst-case item of two results
  assign stat_o.room  = (level_q <= Q_LVL_W'(Q_DEPTH - 2));
  assign stat_o.level = level_q;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.cnt == 2'd2) mem_q[wr_q + Q_PTR_W'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_q + Q_PTR_W'(push_i.cnt);
      rd_q    <= rd_q + Q_PTR_W'(pop);
      level_q <= level_q + Q_LVL_W'(push_i.cnt) - Q_LVL_W'(pop);
    end
  end

endmodule

// ----- design/annexb_nal_unit_splitter.sv -----
// Top level of the Annex B NAL unit splitter.
// Takes one stream byte per clock while in_i.ready is high and reports each NAL unit as
// offset, length and type once its end is known; a byte yields zero, one or two results
// (run_last marks the last one). The running state is updated in the cycle the byte is
// accepted and results enter a four-entry queue in that same edge, so each result is registered
// in the queue before it appears at the output. in_i.ready stays high while the queue has two
// free entries; with the output side taking one result per clock the input runs at one byte per
// cycle, slowing only when bytes yield two results. Positions saturate at 2**POSITION_BITS - 1.
module annexb_nal_unit_splitter #(
  parameter int POSITION_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ans_byte_if.sink   in_i,
  ans_unit_if.source out_o
);
  import ans_pkg::*;

  push_t   push;
  q_stat_t stat;

  ans_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .stat_i (stat),
    .push_o (push)
  );

  ans_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .out_o  (out_o),
    .stat_o (stat)
  );

  a_push_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != 2'd0) |-> (in_i.valid && in_i.ready))
    else $error("results pushed without an accepted item");

  a_push_max_two : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.cnt != 2'd3)
    else $error("more than two results for one item");

  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.level <= Q_LVL_W'(Q_DEPTH))
    else $error("result queue overflow");

  a_empty_no_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.level == '0) |-> !out_o.valid)
    else $error("output valid with an empty queue");

endmodule
